FILE: design/scoped_symbol_hash_table_unit_defines.svh
// Assertion helpers
`ifndef SCOPED_SYMBOL_HASH_TABLE_UNIT_DEFINES_SVH
`define SCOPED_SYMBOL_HASH_TABLE_UNIT_DEFINES_SVH

`define SSHT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SSHT_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ssht_pkg.sv
package ssht_pkg;

    typedef enum logic [1:0] {
        ACT_OPEN   = 2'd0,
        ACT_CLOSE  = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_LOOKUP = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_TOO_MANY  = 3'd3,
        ST_NO_SCOPE  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_MOD,
        S_CLEAR,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    localparam int HASH_SEED = 7;
    localparam int HASH_MUL  = 31;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key_name;
        logic [7:0]  entry_type;
        logic        is_array;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] found_type;
        logic       found_is_array;
    } rsp_t;

endpackage

FILE: design/ssht_if.sv
interface ssht_if #(
    parameter int W = 1
) (
    input logic clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/ssht_hash.sv
module ssht_hash import ssht_pkg::*; #(
    parameter int TABLE_SIZE = 20,
    parameter int NAME_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [63:0]                   name,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] slot
);
    localparam int SW = $clog2(TABLE_SIZE);
    localparam int BW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

    // remainder carried per byte: r' = ((r*31) mod T + b mod T) mod T
    function automatic logic [TABLE_SIZE*SW-1:0] mul_tab();
        logic [TABLE_SIZE*SW-1:0] t;
        t = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            t[i*SW +: SW] = SW'((i * HASH_MUL) % TABLE_SIZE);
        end
        return t;
    endfunction

    function automatic logic [256*SW-1:0] byte_tab();
        logic [256*SW-1:0] t;
        t = '0;
        for (int i = 0; i < 256; i++)
        begin
            t[i*SW +: SW] = SW'(i % TABLE_SIZE);
        end
        return t;
    endfunction

    localparam logic [SW-1:0]            SEED_MOD = SW'(HASH_SEED % TABLE_SIZE);
    localparam logic [TABLE_SIZE*SW-1:0] MUL_MOD  = mul_tab();
    localparam logic [256*SW-1:0]        BYTE_MOD = byte_tab();

    logic [SW-1:0] r_reg, r_next;
    logic [BW:0]   cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [7:0]    b;
    logic [SW:0]   sum;
    logic [SW-1:0] r_step;

    always_comb
    begin
        b = name[8*cnt_reg[BW-1:0] +: 8];
        if (cnt_reg >= (BW+1)'(NAME_BYTES))
        begin
            b = 8'd0;
        end
        sum = {1'b0, MUL_MOD[32'(r_reg)*SW +: SW]} + {1'b0, BYTE_MOD[32'(b)*SW +: SW]};
        if (sum >= (SW+1)'(TABLE_SIZE))
        begin
            r_step = SW'(sum - (SW+1)'(TABLE_SIZE));
        end
        else
        begin
            r_step = sum[SW-1:0];
        end
    end

    always_comb
    begin
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            r_next    = SEED_MOD;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b == 8'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                r_next   = r_step;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign slot = r_reg;
endmodule

FILE: design/scoped_symbol_hash_table_unit.sv
// From accept to result valid, the hash steps through the name one byte at a time,
// up to NAME_BYTES bytes; open then clears the TABLE_SIZE used bits of the new scope.
// Insert then probes occupied slots until it writes a free one.
// Lookup then probes slots from the innermost open scope outward;
// worst case probes MAX_SCOPES*TABLE_SIZE slots. One item at a time: the next item is
// taken only once the result has been delivered.
// Reset: asynchronous active low; no scope open, used bits live in flip-flops.
`include "scoped_symbol_hash_table_unit_defines.svh"
module scoped_symbol_hash_table_unit import ssht_pkg::*; #(
    parameter int TABLE_SIZE = 20,
    parameter int MAX_SCOPES = 8,
    parameter int NAME_BYTES = 8
) (
    input logic clk,
    input logic rst_n,
    ssht_if.sink   req,
    ssht_if.source rsp
);
    localparam int SLOTS = TABLE_SIZE * MAX_SCOPES;
    localparam int AW = $clog2(SLOTS);
    localparam int SW = $clog2(TABLE_SIZE);
    localparam int DW = $clog2(MAX_SCOPES + 1);
    localparam int KW = $clog2(TABLE_SIZE + 1);

    state_t state_reg, state_next;
    req_t   req_reg;
    rsp_t   rsp_reg, rsp_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [DW-1:0] scope_reg, scope_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic [KW-1:0] k_reg, k_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [63:0] clip;
    logic        hash_start, hash_done;
    logic [SW-1:0] hash_slot;
    logic [AW-1:0] addr;
    logic        mem_we;
    logic [72:0] mem [SLOTS];
    logic [72:0] rd_reg;
    logic        cur_used;

    always_comb
    begin
        logic stop;
        clip = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (i >= NAME_BYTES || req.data[9+8*i +: 8] == 8'd0)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                clip[8*i +: 8] = req.data[9+8*i +: 8];
            end
        end
    end

    ssht_hash #(.TABLE_SIZE(TABLE_SIZE), .NAME_BYTES(NAME_BYTES)) u_hash (
        .clk(clk), .rst_n(rst_n), .start(hash_start), .name(req_reg.key_name),
        .done(hash_done), .slot(hash_slot)
    );

    assign addr = AW'((32'(scope_reg) - 32'd1) * 32'(TABLE_SIZE) + 32'(pos_reg));
    assign cur_used = used_reg[addr];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= {req_reg.key_name, req_reg.entry_type, req_reg.is_array};
        end
        rd_reg <= mem[addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        depth_next     = depth_reg;
        scope_next     = scope_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        used_next      = used_reg;
        hash_start     = 1'b0;
        mem_we         = 1'b0;
        req.ready      = 1'b0;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                req.ready = !rsp_valid_reg;
                if (req.valid && !rsp_valid_reg)
                begin
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                rsp_next = '{status: ST_OK, found_type: 8'd0, found_is_array: 1'b0};
                if (hash_done)
                begin
                    pos_next   = hash_slot;
                    k_next     = '0;
                    scope_next = depth_reg;
                    state_next = S_DONE;
                    case (action_t'(req_reg.action))
                        ACT_OPEN:
                        begin
                            if (32'(depth_reg) >= MAX_SCOPES)
                                rsp_next.status = ST_TOO_MANY;
                            else
                            begin
                                scope_next = depth_reg + 1'b1;
                                pos_next   = '0;
                                state_next = S_CLEAR;
                            end
                        end
                        ACT_CLOSE:
                        begin
                            if (depth_reg == '0)
                                rsp_next.status = ST_NO_SCOPE;
                            else
                                depth_next = depth_reg - 1'b1;
                        end
                        ACT_INSERT:
                        begin
                            if (depth_reg == '0)
                                rsp_next.status = ST_NO_SCOPE;
                            else
                                state_next = S_READ;
                        end
                        default:
                        begin
                            if (depth_reg == '0)
                                rsp_next.status = ST_NOT_FOUND;
                            else
                                state_next = S_READ;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                used_next[addr] = 1'b0;
                if (32'(pos_reg) == TABLE_SIZE - 1)
                begin
                    depth_next = scope_reg;
                    state_next = S_DONE;
                end
                else
                    pos_next = pos_reg + 1'b1;
            end
            S_READ:
            begin
                if (req_reg.action == ACT_INSERT)
                begin
                    if (!cur_used)
                    begin
                        used_next[addr] = 1'b1;
                        mem_we     = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_MOD;
                end
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (cur_used && rd_reg[72:9] == req_reg.key_name)
                begin
                    rsp_next.found_type     = rd_reg[8:1];
                    rsp_next.found_is_array = rd_reg[0];
                    state_next = S_DONE;
                end
                else if (!cur_used || 32'(k_reg) == TABLE_SIZE - 1)
                begin
                    if (scope_reg == DW'(1))
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        scope_next = scope_reg - 1'b1;
                        pos_next   = hash_slot;
                        k_next     = '0;
                        state_next = S_READ;
                    end
                end
                else
                    state_next = S_MOD;
            end
            S_MOD:
            begin
                if (32'(k_reg) == TABLE_SIZE - 1)
                begin
                    rsp_next.status = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    pos_next   = (32'(pos_reg) == TABLE_SIZE - 1) ? '0 : pos_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            depth_reg     <= '0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            depth_reg     <= depth_next;
            used_reg      <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= '{action: req.data[74:73], key_name: clip,
                         entry_type: req.data[8:1], is_array: req.data[0]};
        end
        rsp_reg   <= rsp_next;
        scope_reg <= scope_next;
        pos_reg   <= pos_next;
        k_reg     <= k_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    `SSHT_ASSERT(a_depth_max, clk, rst_n, 32'(depth_reg) <= MAX_SCOPES, "depth overflow")
    `SSHT_ASSERT(a_no_take_busy, clk, rst_n, req.ready |-> state_reg == S_IDLE && !rsp_valid_reg, "accept while busy")
    `SSHT_ASSERT(a_hit_ok, clk, rst_n, rsp.valid && rsp_reg.status != ST_OK |-> rsp_reg.found_type == 8'd0, "type on miss")
    `SSHT_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !rsp.valid || !rst_n, "output valid after reset")
endmodule
